@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond) `ASSERT_AT(lbl, !(cond))

`endif

@@ hw/rtl/i2cbb_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Types, codes and sizing constants of the I2C bit-bang master.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

  localparam int unsigned SamplesPerHalf = 5;
  localparam int unsigned FifoDepth      = 16;

  localparam int unsigned TickW = $clog2(SamplesPerHalf + 1);
  localparam int unsigned PtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_LOAD  = 2'd2
  } i2cbb_opcode_e;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_OK     = 2'd1,
    ST_NACK   = 2'd2,
    ST_REJECT = 2'd3
  } i2cbb_status_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TX_LO, PH_TX_HI,
    PH_AK_LO, PH_AK_HI, PH_AK_END, PH_RX_HI, PH_RX_LO,
    PH_MA_A, PH_MA_B, PH_MA_C, PH_MA_D, PH_MN_A, PH_MN_B, PH_MN_C,
    PH_SP_A, PH_SP_B, PH_SP_C
  } i2cbb_phase_e;

  // Circular FIFO pointer advance.
  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(FifoDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/i2c_bitbang_master.sv @@
// ----------------------------------------------------------------------------
// i2c_bitbang_master
// I2C master that runs one message per begin command, paced by tick items.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): tuser carries the opcode (tick, begin, load).
//   Load pushes a write byte into a 16-entry FIFO while idle. Begin starts
//   START, address byte, data bytes (write from FIFO, or read), STOP. A write
//   begin asking for more bytes than the FIFO holds is rejected. Ticks pace
//   the bus: five ticks make one half SCL period; sda_in is sampled on ticks.
//   Output stream (m_axis_*): exactly one transaction per input transaction,
//   carrying the line levels after that item, a received byte when one
//   completes, busy, and the message status (ok / NACK / rejected).
//   Result: registered, and valid in the cycle after the input is accepted.
//   Throughput: one item per cycle unless stalled; all state is updated in
//   the accepting cycle by the phase machine, the result in an output register.
//   Stall: while a result is held unread, a new item is still taken if the
//   held result leaves in the same cycle; otherwise s_axis_tready drops.
//   Reset: phase idle, FIFO empty, both lines released, no result pending.
//   FIFO contents are not cleared; only entries that were loaded are read.
// ----------------------------------------------------------------------------
module i2c_bitbang_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [6:0] dev_addr, [7] read_not_write, [15:8] msg_len, [23:16] data_byte,
  // [24] sda_in, [31:25] zero
  input  logic [31:0] s_axis_tdata_i,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] scl_out, [1] sda_out, [2] rx_valid, [10:3] rx_byte, [11] busy_res,
  // [13:12] status, [15:14] zero
  output logic [15:0] m_axis_tdata_o
);

  // input fields
  logic [6:0] in_addr;
  logic       in_rnw;
  logic [7:0] in_len;
  logic [7:0] in_data;
  logic       in_sda;
  logic [1:0] in_opcode;

  assign in_addr   = s_axis_tdata_i[6:0];
  assign in_rnw    = s_axis_tdata_i[7];
  assign in_len    = s_axis_tdata_i[15:8];
  assign in_data   = s_axis_tdata_i[23:16];
  assign in_sda    = s_axis_tdata_i[24];
  assign in_opcode = s_axis_tuser_i;

  // state
  i2cbb_pkg::i2cbb_phase_e                phase_q, phase_d;
  logic [i2cbb_pkg::TickW-1:0]            tick_q, tick_d;
  logic [i2cbb_pkg::TickW:0]              tick_inc;
  logic [3:0]                             bit_q, bit_d, bit_inc;
  logic [7:0]                             shift_q, shift_d;
  logic [7:0]                             bytes_q, bytes_d, bytes_dec;
  logic                                   rmode_q, rmode_d;
  logic                                   ack_q, ack_d;
  logic                                   scl_q, scl_d;
  logic                                   sda_q, sda_d;
  logic [i2cbb_pkg::CntW-1:0]             cnt_q, cnt_d;
  logic [i2cbb_pkg::PtrW-1:0]             rd_q, rd_d;
  logic [i2cbb_pkg::PtrW-1:0]             wr_q, wr_d;
  logic [7:0]                             fifo_mem_q [i2cbb_pkg::FifoDepth];
  logic [7:0]                             fifo_rd_data;
  logic                                   fifo_we;

  // per-item result
  logic                                   half_end;
  logic                                   entered;
  logic                                   rx_valid;
  logic [7:0]                             rx_byte;
  i2cbb_pkg::i2cbb_status_e               status;

  // handshake
  logic                                   accept;
  logic                                   m_valid_q;
  logic [15:0]                            out_q;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  assign tick_inc     = {1'b0, tick_q} + (i2cbb_pkg::TickW + 1)'(1);
  assign bit_inc      = bit_q + 4'd1;
  assign bytes_dec    = bytes_q - 8'd1;
  assign fifo_rd_data = fifo_mem_q[rd_q];

  // Next state: phase machine and datapath
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    bytes_d  = bytes_q;
    rmode_d  = rmode_q;
    ack_d    = ack_q;
    cnt_d    = cnt_q;
    rd_d     = rd_q;
    wr_d     = wr_q;
    fifo_we  = 1'b0;
    half_end = 1'b0;
    entered  = 1'b0;
    rx_valid = 1'b0;
    rx_byte  = 8'h00;
    status   = i2cbb_pkg::ST_NONE;

    case (in_opcode)
      i2cbb_pkg::OP_TICK: begin
        if (phase_q == i2cbb_pkg::PH_AK_HI && !in_sda) begin
          ack_d    = 1'b1;
          half_end = 1'b1;
        end else if (phase_q != i2cbb_pkg::PH_IDLE) begin
          tick_d   = tick_inc[i2cbb_pkg::TickW-1:0];
          half_end = (tick_inc >= (i2cbb_pkg::TickW + 1)'(i2cbb_pkg::SamplesPerHalf));
        end
      end
      i2cbb_pkg::OP_BEGIN: begin
        if (phase_q == i2cbb_pkg::PH_IDLE) begin
          if (!in_rnw && (in_len > 8'(cnt_q))) begin
            status = i2cbb_pkg::ST_REJECT;
          end else begin
            rmode_d = in_rnw;
            bytes_d = in_len;
            shift_d = {in_addr, in_rnw};
            bit_d   = 4'd0;
            ack_d   = 1'b0;
            phase_d = i2cbb_pkg::PH_ST_A;
            entered = 1'b1;
          end
        end
      end
      i2cbb_pkg::OP_LOAD: begin
        if (phase_q == i2cbb_pkg::PH_IDLE &&
            cnt_q < i2cbb_pkg::CntW'(i2cbb_pkg::FifoDepth)) begin
          fifo_we = 1'b1;
          wr_d    = i2cbb_pkg::ptr_next(wr_q);
          cnt_d   = cnt_q + i2cbb_pkg::CntW'(1);
        end
      end
      default: ;
    endcase

    if (half_end) begin
      entered = 1'b1;
      case (phase_q)
        i2cbb_pkg::PH_ST_A: phase_d = i2cbb_pkg::PH_ST_B;
        i2cbb_pkg::PH_ST_B: phase_d = i2cbb_pkg::PH_ST_C;
        i2cbb_pkg::PH_ST_C: begin
          bit_d   = 4'd0;
          phase_d = i2cbb_pkg::PH_TX_LO;
        end
        i2cbb_pkg::PH_TX_LO: phase_d = i2cbb_pkg::PH_TX_HI;
        i2cbb_pkg::PH_TX_HI: begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_inc;
          phase_d = (bit_inc >= 4'd8) ? i2cbb_pkg::PH_AK_LO : i2cbb_pkg::PH_TX_LO;
        end
        i2cbb_pkg::PH_AK_LO: begin
          ack_d   = 1'b0;
          phase_d = i2cbb_pkg::PH_AK_HI;
        end
        i2cbb_pkg::PH_AK_HI: phase_d = i2cbb_pkg::PH_AK_END;
        i2cbb_pkg::PH_AK_END: begin
          if (!ack_q) begin
            phase_d = i2cbb_pkg::PH_SP_A;
          end else if (rmode_q) begin
            if (bytes_q == 8'd0) begin
              phase_d = i2cbb_pkg::PH_MN_A;
            end else begin
              shift_d = 8'h00;
              bit_d   = 4'd0;
              phase_d = i2cbb_pkg::PH_RX_HI;
            end
          end else if (bytes_q == 8'd0 || cnt_q == '0) begin
            phase_d = i2cbb_pkg::PH_SP_A;
          end else begin
            // pop the next write byte
            shift_d = fifo_rd_data;
            rd_d    = i2cbb_pkg::ptr_next(rd_q);
            cnt_d   = cnt_q - i2cbb_pkg::CntW'(1);
            bytes_d = bytes_dec;
            bit_d   = 4'd0;
            phase_d = i2cbb_pkg::PH_TX_LO;
          end
        end
        i2cbb_pkg::PH_RX_HI: begin
          shift_d = {shift_q[6:0], in_sda};
          phase_d = i2cbb_pkg::PH_RX_LO;
        end
        i2cbb_pkg::PH_RX_LO: begin
          bit_d = bit_inc;
          if (bit_inc < 4'd8) begin
            phase_d = i2cbb_pkg::PH_RX_HI;
          end else begin
            rx_valid = 1'b1;
            rx_byte  = shift_q;
            if (bytes_q != 8'd0) begin
              bytes_d = bytes_dec;
            end
            // ACK while more bytes follow, else the final NACK
            if (bytes_q != 8'd0 && bytes_dec != 8'd0) begin
              phase_d = i2cbb_pkg::PH_MA_A;
            end else begin
              phase_d = i2cbb_pkg::PH_MN_A;
            end
          end
        end
        i2cbb_pkg::PH_MA_A: phase_d = i2cbb_pkg::PH_MA_B;
        i2cbb_pkg::PH_MA_B: phase_d = i2cbb_pkg::PH_MA_C;
        i2cbb_pkg::PH_MA_C: phase_d = i2cbb_pkg::PH_MA_D;
        i2cbb_pkg::PH_MA_D: begin
          shift_d = 8'h00;
          bit_d   = 4'd0;
          phase_d = i2cbb_pkg::PH_RX_HI;
        end
        i2cbb_pkg::PH_MN_A: phase_d = i2cbb_pkg::PH_MN_B;
        i2cbb_pkg::PH_MN_B: phase_d = i2cbb_pkg::PH_MN_C;
        i2cbb_pkg::PH_MN_C: phase_d = i2cbb_pkg::PH_SP_A;
        i2cbb_pkg::PH_SP_A: phase_d = i2cbb_pkg::PH_SP_B;
        i2cbb_pkg::PH_SP_B: phase_d = i2cbb_pkg::PH_SP_C;
        i2cbb_pkg::PH_SP_C: begin
          status  = ack_q ? i2cbb_pkg::ST_OK : i2cbb_pkg::ST_NACK;
          phase_d = i2cbb_pkg::PH_IDLE;
        end
        default: phase_d = i2cbb_pkg::PH_IDLE;
      endcase
    end

    if (entered) begin
      tick_d = '0;
    end
  end

  // Outputs: line levels set on entry to a phase
  always_comb begin
    scl_d = scl_q;
    sda_d = sda_q;
    if (entered) begin
      case (phase_d)
        i2cbb_pkg::PH_ST_A:   begin sda_d = 1'b1; scl_d = 1'b1; end
        i2cbb_pkg::PH_ST_B:   sda_d = 1'b0;
        i2cbb_pkg::PH_ST_C:   scl_d = 1'b0;
        i2cbb_pkg::PH_TX_LO:  begin sda_d = shift_d[7]; scl_d = 1'b0; end
        i2cbb_pkg::PH_TX_HI:  scl_d = 1'b1;
        i2cbb_pkg::PH_AK_LO:  begin sda_d = 1'b1; scl_d = 1'b0; end
        i2cbb_pkg::PH_AK_HI:  scl_d = 1'b1;
        i2cbb_pkg::PH_AK_END: scl_d = 1'b0;
        i2cbb_pkg::PH_RX_HI:  begin sda_d = 1'b1; scl_d = 1'b1; end
        i2cbb_pkg::PH_RX_LO:  scl_d = 1'b0;
        i2cbb_pkg::PH_MA_A:   sda_d = 1'b0;
        i2cbb_pkg::PH_MA_B:   scl_d = 1'b1;
        i2cbb_pkg::PH_MA_C:   scl_d = 1'b0;
        i2cbb_pkg::PH_MA_D:   sda_d = 1'b1;
        i2cbb_pkg::PH_MN_A:   sda_d = 1'b1;
        i2cbb_pkg::PH_MN_B:   scl_d = 1'b1;
        i2cbb_pkg::PH_MN_C:   scl_d = 1'b0;
        i2cbb_pkg::PH_SP_A:   sda_d = 1'b0;
        i2cbb_pkg::PH_SP_B:   scl_d = 1'b1;
        i2cbb_pkg::PH_SP_C:   sda_d = 1'b1;
        default:              begin sda_d = 1'b1; scl_d = 1'b1; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cbb_pkg::PH_IDLE;
      tick_q  <= '0;
      bit_q   <= 4'd0;
      shift_q <= 8'h00;
      bytes_q <= 8'h00;
      rmode_q <= 1'b0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      cnt_q   <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      bytes_q <= bytes_d;
      rmode_q <= rmode_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && fifo_we) begin
      fifo_mem_q[wr_q] <= in_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= {2'b00, status, (phase_d != i2cbb_pkg::PH_IDLE), rx_byte, rx_valid,
                sda_d, scl_d};
    end
  end

  `include "assert_macros.svh"

  `ASSERT_NEVER(a_fifo_overfill, cnt_q > i2cbb_pkg::CntW'(i2cbb_pkg::FifoDepth))
  `ASSERT_AT(a_idle_released, (phase_q == i2cbb_pkg::PH_IDLE) |-> (scl_q && sda_q))
  `ASSERT_AT(a_hold_without_item, !accept |=> $stable(phase_q) && $stable(cnt_q))
  `ASSERT_AT(a_result_follows, accept |=> m_valid_q)
  `ASSERT_AT(a_busy_matches_phase,
             accept |=> (out_q[11] == (phase_q != i2cbb_pkg::PH_IDLE)))

endmodule

@@ dv/i2c_bitbang_master_test.sv @@
// ----------------------------------------------------------------------------
// i2c_bitbang_master_test
// Self-checking bench for the I2C bit-bang master. Commands and tick
// transactions go into the input stream. Every transaction is run through a
// local model of the phase machine. Each output transaction is checked
// field by field against the oldest predicted result. Directed messages
// come first: rejects, NACK on address and data, FIFO overflow and commands
// while busy. Random write/read traffic follows, with a simulated target
// that ACKs, NACKs and returns data. Both stream sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module i2c_bitbang_master_test;

  localparam logic [1:0]  OpUnused      = 2'd3;
  localparam int unsigned SdaBit        = 24;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainLimit    = 100;
  localparam int unsigned DrainCycles   = 4;

  // result word as it appears on m_axis_tdata_o, MSB first
  typedef struct packed {
    logic [1:0] pad;
    logic [1:0] status;
    logic       busy;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       sda;
    logic       scl;
  } bus_result_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic [31:0] s_data   = '0;
  logic [1:0]  s_user   = '0;
  logic        m_ready  = 1'b1;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;

  logic        idle_en      = 1'b1;
  logic        hold_request = 1'b0;
  int unsigned err_count    = 0;
  int unsigned items_sent   = 0;

  bus_result_t expected_bus_q[$];

  // bus model state
  i2cbb_pkg::i2cbb_phase_e    ph           = i2cbb_pkg::PH_IDLE;
  logic [2:0]                 tick_cnt     = '0;
  logic [3:0]                 bit_cnt      = '0;
  logic [7:0]                 shreg        = '0;
  logic [7:0]                 bytes_left_m = '0;
  logic                       rmode        = 1'b0;
  logic                       acked        = 1'b0;
  logic                       scl_m        = 1'b1;
  logic                       sda_m        = 1'b1;
  logic [7:0]                 fifo_mem [i2cbb_pkg::FifoDepth];
  logic [i2cbb_pkg::CntW-1:0] fifo_cnt     = '0;
  logic [i2cbb_pkg::PtrW-1:0] rd_ptr       = '0;
  logic [i2cbb_pkg::PtrW-1:0] wr_ptr       = '0;
  bus_result_t                cur_res;

  i2c_bitbang_master dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    // [6:0] dev_addr, [7] read_not_write, [15:8] msg_len, [23:16] data_byte,
    // [24] sda_in, [31:25] zero
    .s_axis_tdata_i  (s_data),
    // [1:0] opcode
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    // [0] scl_out, [1] sda_out, [2] rx_valid, [10:3] rx_byte, [11] busy_res,
    // [13:12] status, [15:14] zero
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model

  function automatic logic [i2cbb_pkg::PtrW-1:0] fifo_ptr_bump(
      input logic [i2cbb_pkg::PtrW-1:0] p);
    return (p == i2cbb_pkg::PtrW'(i2cbb_pkg::FifoDepth - 1)) ? '0 :
           p + i2cbb_pkg::PtrW'(1);
  endfunction

  function automatic void enter_phase(input i2cbb_pkg::i2cbb_phase_e p);
    ph = p;
    tick_cnt = '0;
    case (p)
      i2cbb_pkg::PH_ST_A: begin
        sda_m = 1'b1;
        scl_m = 1'b1;
      end
      i2cbb_pkg::PH_ST_B: sda_m = 1'b0;
      i2cbb_pkg::PH_ST_C: scl_m = 1'b0;
      i2cbb_pkg::PH_TX_LO: begin
        sda_m = shreg[7];
        scl_m = 1'b0;
      end
      i2cbb_pkg::PH_TX_HI: scl_m = 1'b1;
      i2cbb_pkg::PH_AK_LO: begin
        sda_m = 1'b1;
        scl_m = 1'b0;
      end
      i2cbb_pkg::PH_AK_HI: begin
        scl_m = 1'b1;
        acked = 1'b0;
      end
      i2cbb_pkg::PH_AK_END: scl_m = 1'b0;
      i2cbb_pkg::PH_RX_HI: begin
        sda_m = 1'b1;
        scl_m = 1'b1;
      end
      i2cbb_pkg::PH_RX_LO: scl_m = 1'b0;
      i2cbb_pkg::PH_MA_A:  sda_m = 1'b0;
      i2cbb_pkg::PH_MA_B:  scl_m = 1'b1;
      i2cbb_pkg::PH_MA_C:  scl_m = 1'b0;
      i2cbb_pkg::PH_MA_D:  sda_m = 1'b1;
      i2cbb_pkg::PH_MN_A:  sda_m = 1'b1;
      i2cbb_pkg::PH_MN_B:  scl_m = 1'b1;
      i2cbb_pkg::PH_MN_C:  scl_m = 1'b0;
      i2cbb_pkg::PH_SP_A:  sda_m = 1'b0;
      i2cbb_pkg::PH_SP_B:  scl_m = 1'b1;
      i2cbb_pkg::PH_SP_C:  sda_m = 1'b1;
      default: begin
        sda_m = 1'b1;
        scl_m = 1'b1;
      end
    endcase
  endfunction

  function automatic void shift_out_byte(input logic [7:0] b);
    shreg = b;
    bit_cnt = '0;
    enter_phase(i2cbb_pkg::PH_TX_LO);
  endfunction

  function automatic void shift_in_byte();
    shreg = '0;
    bit_cnt = '0;
    enter_phase(i2cbb_pkg::PH_RX_HI);
  endfunction

  // end of one half SCL period in the current phase
  function automatic void half_period_done(input logic sda);
    logic [7:0] b;
    case (ph)
      i2cbb_pkg::PH_ST_A: enter_phase(i2cbb_pkg::PH_ST_B);
      i2cbb_pkg::PH_ST_B: enter_phase(i2cbb_pkg::PH_ST_C);
      i2cbb_pkg::PH_ST_C: shift_out_byte(shreg);
      i2cbb_pkg::PH_TX_LO: enter_phase(i2cbb_pkg::PH_TX_HI);
      i2cbb_pkg::PH_TX_HI: begin
        shreg = shreg << 1;
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt >= 4'd8) enter_phase(i2cbb_pkg::PH_AK_LO);
        else enter_phase(i2cbb_pkg::PH_TX_LO);
      end
      i2cbb_pkg::PH_AK_LO: enter_phase(i2cbb_pkg::PH_AK_HI);
      i2cbb_pkg::PH_AK_HI: enter_phase(i2cbb_pkg::PH_AK_END);
      i2cbb_pkg::PH_AK_END: begin
        if (!acked) begin
          enter_phase(i2cbb_pkg::PH_SP_A);
        end else if (rmode) begin
          if (bytes_left_m == 0) enter_phase(i2cbb_pkg::PH_MN_A);
          else shift_in_byte();
        end else if (bytes_left_m == 0 || fifo_cnt == 0) begin
          enter_phase(i2cbb_pkg::PH_SP_A);
        end else begin
          b = fifo_mem[rd_ptr];
          rd_ptr = fifo_ptr_bump(rd_ptr);
          fifo_cnt = fifo_cnt - 1'b1;
          bytes_left_m = bytes_left_m - 1'b1;
          shift_out_byte(b);
        end
      end
      i2cbb_pkg::PH_RX_HI: begin
        shreg = {shreg[6:0], sda};
        enter_phase(i2cbb_pkg::PH_RX_LO);
      end
      i2cbb_pkg::PH_RX_LO: begin
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt < 4'd8) begin
          enter_phase(i2cbb_pkg::PH_RX_HI);
        end else begin
          cur_res.rx_valid = 1'b1;
          cur_res.rx_byte = shreg;
          if (bytes_left_m != 0) bytes_left_m = bytes_left_m - 1'b1;
          if (bytes_left_m != 0) enter_phase(i2cbb_pkg::PH_MA_A);
          else enter_phase(i2cbb_pkg::PH_MN_A);
        end
      end
      i2cbb_pkg::PH_MA_A: enter_phase(i2cbb_pkg::PH_MA_B);
      i2cbb_pkg::PH_MA_B: enter_phase(i2cbb_pkg::PH_MA_C);
      i2cbb_pkg::PH_MA_C: enter_phase(i2cbb_pkg::PH_MA_D);
      i2cbb_pkg::PH_MA_D: shift_in_byte();
      i2cbb_pkg::PH_MN_A: enter_phase(i2cbb_pkg::PH_MN_B);
      i2cbb_pkg::PH_MN_B: enter_phase(i2cbb_pkg::PH_MN_C);
      i2cbb_pkg::PH_MN_C: enter_phase(i2cbb_pkg::PH_SP_A);
      i2cbb_pkg::PH_SP_A: enter_phase(i2cbb_pkg::PH_SP_B);
      i2cbb_pkg::PH_SP_B: enter_phase(i2cbb_pkg::PH_SP_C);
      i2cbb_pkg::PH_SP_C: begin
        cur_res.status = acked ? i2cbb_pkg::ST_OK : i2cbb_pkg::ST_NACK;
        enter_phase(i2cbb_pkg::PH_IDLE);
      end
      default: enter_phase(i2cbb_pkg::PH_IDLE);
    endcase
  endfunction

  function automatic void predict_bus_item(input logic [1:0] op, input logic [31:0] d);
    logic [6:0] addr;
    logic       rnw;
    logic [7:0] len;
    logic [7:0] data_v;
    logic       sda;
    addr   = d[6:0];
    rnw    = d[7];
    len    = d[15:8];
    data_v = d[23:16];
    sda    = d[SdaBit];
    cur_res = '0;
    cur_res.status = i2cbb_pkg::ST_NONE;
    case (op)
      i2cbb_pkg::OP_TICK: begin
        if (ph == i2cbb_pkg::PH_AK_HI && !sda) begin
          acked = 1'b1;
          half_period_done(sda);
        end else if (ph != i2cbb_pkg::PH_IDLE) begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= 3'(i2cbb_pkg::SamplesPerHalf)) half_period_done(sda);
        end
      end
      i2cbb_pkg::OP_BEGIN: begin
        if (ph == i2cbb_pkg::PH_IDLE) begin
          if (!rnw && len > fifo_cnt) begin
            cur_res.status = i2cbb_pkg::ST_REJECT;
          end else begin
            rmode = rnw;
            bytes_left_m = len;
            shreg = {addr, rnw};
            bit_cnt = '0;
            acked = 1'b0;
            enter_phase(i2cbb_pkg::PH_ST_A);
          end
        end
      end
      i2cbb_pkg::OP_LOAD: begin
        if (ph == i2cbb_pkg::PH_IDLE &&
            fifo_cnt < i2cbb_pkg::CntW'(i2cbb_pkg::FifoDepth)) begin
          fifo_mem[wr_ptr] = data_v;
          wr_ptr = fifo_ptr_bump(wr_ptr);
          fifo_cnt = fifo_cnt + 1'b1;
        end
      end
      default: ;
    endcase
    cur_res.scl  = scl_m;
    cur_res.sda  = sda_m;
    cur_res.busy = (ph != i2cbb_pkg::PH_IDLE);
    expected_bus_q.push_back(cur_res);
  endfunction

  // ------------------------------------------------------------ stimulus

  function automatic logic [31:0] pack_item(input logic [6:0] addr, input logic rnw,
                                            input logic [7:0] len, input logic [7:0] data_v,
                                            input logic sda);
    return {7'd0, sda, data_v, len, rnw, addr};
  endfunction

  function automatic logic [31:0] tick_word(input logic sda);
    logic [31:0] w;
    w = {7'd0, 25'($urandom)};
    w[SdaBit] = sda;
    return w;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [31:0] d);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_bus_item(op, d);
    items_sent++;
  endtask

  task automatic load_byte(input logic [7:0] data_v);
    send_item(i2cbb_pkg::OP_LOAD,
              pack_item(7'($urandom), 1'($urandom), 8'($urandom), data_v, 1'($urandom)));
  endtask

  // Issue begin, then tick until the bus model is idle again. The target ACKs
  // every address/data byte except acknowledge number nack_at (0 = address).
  task automatic run_message(input logic [6:0] addr, input logic rnw, input logic [7:0] len,
                             input int nack_at, input int unsigned noise_pct);
    int         acks_done;
    logic       sda;
    logic [1:0] op;
    acks_done = 0;
    send_item(i2cbb_pkg::OP_BEGIN, pack_item(addr, rnw, len, 8'($urandom), 1'($urandom)));
    while (ph != i2cbb_pkg::PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0: op = i2cbb_pkg::OP_BEGIN;
          1: op = i2cbb_pkg::OP_LOAD;
          default: op = OpUnused;
        endcase
        send_item(op, {7'd0, 25'($urandom)});
      end else begin
        if (ph == i2cbb_pkg::PH_AK_HI) begin
          if (nack_at >= 0 && acks_done == nack_at) sda = 1'b1;
          else if (tick_cnt == 3'(i2cbb_pkg::SamplesPerHalf - 1)) sda = 1'b0;
          else sda = 1'($urandom);
          if (!sda) acks_done++;
        end else begin
          sda = 1'($urandom);
        end
        send_item(i2cbb_pkg::OP_TICK, tick_word(sda));
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_idle_commands();
    send_item(i2cbb_pkg::OP_TICK, tick_word(1'b0));
    send_item(i2cbb_pkg::OP_TICK, tick_word(1'b1));
    send_item(OpUnused, {7'd0, 25'($urandom)});
    load_byte(8'h00);
    load_byte(8'hFF);
    // write asking for more bytes than loaded
    run_message(7'h12, 1'b0, 8'd3, -1, 0);
  endtask

  task automatic test_write_messages();
    run_message(7'h7F, 1'b0, 8'd2, -1, 0);
    run_message(7'h00, 1'b0, 8'd0, -1, 0);
    run_message(7'h40, 1'b0, 8'd255, -1, 0);
  endtask

  task automatic test_read_messages();
    // commands while busy are dropped
    run_message(7'h55, 1'b1, 8'd0, -1, 25);
    run_message(7'h2A, 1'b1, 8'd2, -1, 0);
  endtask

  task automatic test_nack_recovery();
    load_byte(8'hA5);
    load_byte(8'h5A);
    run_message(7'h33, 1'b0, 8'd2, 1, 0);   // NACK on first data byte
    run_message(7'h33, 1'b0, 8'd1, 0, 0);   // NACK on address
    run_message(7'h33, 1'b0, 8'd1, -1, 0);  // leftover goes out
  endtask

  task automatic test_fifo_limits();
    // one more load than the FIFO holds, then a write for one byte too many
    for (int i = 0; i <= i2cbb_pkg::FifoDepth; i++) load_byte(8'($urandom));
    run_message(7'h0F, 1'b0, 8'(i2cbb_pkg::FifoDepth + 1), -1, 0);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    run_message(7'h61, 1'b0, 8'd1, -1, 0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    int unsigned loads;
    logic        rnw;
    logic [7:0]  len;
    int          nack_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      rnw = ($urandom_range(0, 9) < 4);
      r = $urandom_range(0, 19);
      if (rnw) begin
        len = (r < 17) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(4, 12));
      end else begin
        len = (r < 16) ? 8'($urandom_range(0, 3)) :
              (r < 19) ? 8'($urandom_range(4, i2cbb_pkg::FifoDepth)) :
                         8'($urandom_range(17, 255));
        loads = (len > fifo_cnt) ? len - fifo_cnt : 0;
        if ($urandom_range(0, 9) == 0) loads = 0;
        if (loads > i2cbb_pkg::FifoDepth) loads = i2cbb_pkg::FifoDepth;
        loads += $urandom_range(0, 2);
        repeat (loads) load_byte(8'($urandom));
      end
      nack_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, rnw ? 0 : len) : -1;
      run_message(7'($urandom), rnw, len, nack_at, 2);
    end
  endtask

  // ----------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin : bus_check
    bus_result_t got;
    bus_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = m_axis_tdata_o;
      if (expected_bus_q.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
      end else begin
        want = expected_bus_q.pop_front();
        if (got.scl !== want.scl) report_mismatch("scl_out", got.scl, want.scl);
        if (got.sda !== want.sda) report_mismatch("sda_out", got.sda, want.sda);
        if (got.rx_valid !== want.rx_valid) begin
          report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
        end
        if (got.rx_byte !== want.rx_byte) report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.busy !== want.busy) report_mismatch("busy_res", got.busy, want.busy);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.pad !== want.pad) report_mismatch("pad bits", got.pad, want.pad);
      end
    end
  end

  // output-side ready: random short stalls plus one long hold on request
  initial begin : bus_receiver
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main_sequence
    int unsigned waited;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_idle_commands();
    test_write_messages();
    test_read_messages();
    test_nack_recovery();
    test_fifo_limits();
    test_backpressure();
    test_random_traffic(300);
    idle_en = 1'b0;
    test_random_traffic(100);
    @(negedge clk_i);
    s_valid <= 1'b0;
    waited = 0;
    while (expected_bus_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_bus_q.size() != 0) begin
      report_mismatch("results never arrived", 0, expected_bus_q.size());
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
